// ===== src/tfds_pkg.sv =====
// Shared types and constants of the tactile frame demultiplexer and store.
// No dependencies; used by the top level and the checker.
package tfds_pkg;

  localparam int MAX_CARDS   = 4;
  localparam int ID_SLOTS    = 4;
  localparam int NUM_SLOTS   = (MAX_CARDS < ID_SLOTS) ? MAX_CARDS : ID_SLOTS;
  localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SENSORS     = 16;
  localparam int READINGS    = 12;
  localparam int CARD_BYTES  = SENSORS * READINGS;
  localparam int STORE_BYTES = MAX_CARDS * CARD_BYTES;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int LIMIT_W     = ADDR_W + 1;

  localparam int COUNT_W     = 3;
  localparam int CARD_ID_W   = 4;
  localparam int SENSOR_W    = 4;
  localparam int BYTE_W      = 3;
  localparam int PAYLOAD_N   = 7;
  localparam int UPPER_FIRST = 7;
  localparam int LOWER_LAST  = 6;
  localparam int UPPER_LAST  = 4;

  localparam int FRAME_ID_W  = 11;
  localparam int INDEX_W     = 10;
  localparam int IN_TDATA_W  = 88;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CARD_COUNT = 3'd0,
    REG_CARD_ID_0  = 3'd1,
    REG_CARD_ID_1  = 3'd2,
    REG_CARD_ID_2  = 3'd3,
    REG_CARD_ID_3  = 3'd4
  } reg_idx_e;

  typedef enum logic {
    FUNC_FRAME = 1'b0,
    FUNC_READ  = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FRAME,
    ST_RD_WAIT,
    ST_RD_DONE
  } state_e;

endpackage

// ===== src/tactile_frame_demux_store.sv =====
// Top level of the tactile frame demultiplexer and reading store.
// Depends on tfds_pkg and tfds_ram.
//
// The block keeps a byte store of 12 readings per sensor, 16 sensors per board slot, and
// four board slots (768 bytes). A frame request (tuser 0) carries a frame identifier whose
// bits 7..4 name the board and bits 3..0 the sensor; its data bytes are written into every
// slot in use whose configured board number matches. Head byte bit 7 clear puts payload
// bytes 1..7 into readings 0..6, set puts bytes 1..5 into readings 7..11. A read request
// (tuser 1) returns one stored byte on the master side, with tuser set when the position lies
// inside the slots in use; a position beyond them returns 0 with tuser clear. All frame
// bytes go through one RAM write port and one shared address adder, one byte per cycle,
// so a frame visits every slot in turn, passing over a slot that does not match and
// writing 7 (lower group) or 5 (upper group) bytes into each matching slot. A read passes
// through accept, RAM address and RAM data, and waits while the result output is stalled.
// The input stays not ready while an item is in work. After reset the block sweeps the
// RAM to zero, one byte per cycle, before it accepts the first request; configuration
// writes are taken at any time and should only be issued while the block is idle.
module tactile_frame_demux_store (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Input stream.
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // From bit 0: frame_id[10:0], head_byte[18:11], payload_1[26:19], payload_2[34:27],
  // payload_3[42:35], payload_4[50:43], payload_5[58:51], payload_6[66:59],
  // payload_7[74:67], read_index[84:75], zero fill[87:85].
  input  logic [tfds_pkg::IN_TDATA_W-1:0]        s_axis_tdata_i,
  // func: 0 stores a frame, 1 reads one byte.
  input  logic                                   s_axis_tuser_i,
  // Result stream.
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // read_value[7:0].
  output logic [7:0]                             m_axis_tdata_o,
  // index_valid.
  output logic                                   m_axis_tuser_o,
  // Configuration write channel.
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [tfds_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [tfds_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  // Configuration registers.
  logic [tfds_pkg::COUNT_W-1:0]   card_count_q;
  logic [tfds_pkg::CARD_ID_W-1:0] card_id_q [tfds_pkg::ID_SLOTS];

  // Sequencer state and the latched frame.
  tfds_pkg::state_e                state_q, state_d;
  logic [tfds_pkg::ADDR_W-1:0]     clr_cnt_q, clr_cnt_d;
  logic [tfds_pkg::SLOT_W-1:0]     slot_q, slot_d;
  logic [tfds_pkg::BYTE_W-1:0]     byte_q, byte_d;
  logic [tfds_pkg::CARD_ID_W-1:0]  board_q, board_d;
  logic [tfds_pkg::SENSOR_W-1:0]   sensor_q, sensor_d;
  logic                            upper_q, upper_d;
  logic [7:0]                      pay_q [tfds_pkg::PAYLOAD_N];
  logic [tfds_pkg::ADDR_W-1:0]     rd_addr_q, rd_addr_d;
  logic                            rd_ok_q, rd_ok_d;

  // Output register.
  logic                            out_valid_q, out_valid_d;
  logic [7:0]                      out_value_q, out_value_d;
  logic                            out_flag_q, out_flag_d;

  // RAM port signals.
  logic                            ram_we;
  logic [tfds_pkg::ADDR_W-1:0]     ram_waddr;
  logic [7:0]                      ram_wdata;
  logic [7:0]                      ram_rdata;

  // Derived values.
  logic                            s_accept;
  logic [tfds_pkg::COUNT_W-1:0]    slots_in_use;
  logic [tfds_pkg::LIMIT_W-1:0]    read_limit;
  logic [tfds_pkg::INDEX_W-1:0]    in_read_index;
  logic [tfds_pkg::FRAME_ID_W-1:0] in_frame_id;
  logic [7:0]                      in_head;
  logic                            slot_match;
  logic [tfds_pkg::BYTE_W-1:0]     last_byte;
  logic [tfds_pkg::ADDR_W-1:0]     frame_addr;

  assign cfg_ready_o = 1'b1;

  assign in_frame_id   = s_axis_tdata_i[10:0];
  assign in_head       = s_axis_tdata_i[18:11];
  assign in_read_index = s_axis_tdata_i[84:75];

  assign s_axis_tready_o = (state_q == tfds_pkg::ST_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  // Slot count is saturated to the slots that exist.
  assign slots_in_use = (card_count_q > tfds_pkg::COUNT_W'(tfds_pkg::NUM_SLOTS)) ?
                        tfds_pkg::COUNT_W'(tfds_pkg::NUM_SLOTS) : card_count_q;
  assign read_limit   = tfds_pkg::LIMIT_W'(slots_in_use) *
                        tfds_pkg::LIMIT_W'(tfds_pkg::CARD_BYTES);

  // A slot is written only when it is in use and carries the board number of the frame.
  assign slot_match = (tfds_pkg::COUNT_W'(slot_q) < slots_in_use) &&
                      (card_id_q[slot_q] == board_q);
  assign last_byte  = upper_q ? tfds_pkg::BYTE_W'(tfds_pkg::UPPER_LAST) :
                                tfds_pkg::BYTE_W'(tfds_pkg::LOWER_LAST);

  // The shared address adder: slot base, sensor base, group offset and byte number.
  assign frame_addr = tfds_pkg::ADDR_W'(slot_q) * tfds_pkg::ADDR_W'(tfds_pkg::CARD_BYTES) +
                      tfds_pkg::ADDR_W'(sensor_q) * tfds_pkg::ADDR_W'(tfds_pkg::READINGS) +
                      (upper_q ? tfds_pkg::ADDR_W'(tfds_pkg::UPPER_FIRST) : '0) +
                      tfds_pkg::ADDR_W'(byte_q);

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    slot_d      = slot_q;
    byte_d      = byte_q;
    board_d     = board_q;
    sensor_d    = sensor_q;
    upper_d     = upper_q;
    rd_addr_d   = rd_addr_q;
    rd_ok_d     = rd_ok_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_value_d = out_value_q;
    out_flag_d  = out_flag_q;
    ram_we      = 1'b0;
    ram_waddr   = frame_addr;
    ram_wdata   = pay_q[byte_q];

    case (state_q)
      tfds_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == tfds_pkg::ADDR_W'(tfds_pkg::STORE_BYTES - 1)) begin
          state_d = tfds_pkg::ST_IDLE;
        end
      end
      tfds_pkg::ST_IDLE: begin
        if (s_accept) begin
          if (s_axis_tuser_i == tfds_pkg::FUNC_READ) begin
            rd_ok_d   = tfds_pkg::LIMIT_W'(in_read_index) < read_limit;
            rd_addr_d = rd_ok_d ? tfds_pkg::ADDR_W'(in_read_index) : '0;
            state_d   = tfds_pkg::ST_RD_WAIT;
          end else begin
            board_d  = in_frame_id[7:4];
            sensor_d = in_frame_id[3:0];
            upper_d  = in_head[7];
            slot_d   = '0;
            byte_d   = '0;
            state_d  = tfds_pkg::ST_FRAME;
          end
        end
      end
      tfds_pkg::ST_FRAME: begin
        if (slot_match) begin
          ram_we = 1'b1;
        end
        if (!slot_match || byte_q == last_byte) begin
          byte_d = '0;
          if (slot_q == tfds_pkg::SLOT_W'(tfds_pkg::NUM_SLOTS - 1)) begin
            state_d = tfds_pkg::ST_IDLE;
          end else begin
            slot_d = slot_q + 1'b1;
          end
        end else begin
          byte_d = byte_q + 1'b1;
        end
      end
      tfds_pkg::ST_RD_WAIT: begin
        state_d = tfds_pkg::ST_RD_DONE;
      end
      tfds_pkg::ST_RD_DONE: begin
        // The RAM address is held, so the read data stays until the output frees up.
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_value_d = rd_ok_q ? ram_rdata : '0;
          out_flag_d  = rd_ok_q;
          state_d     = tfds_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tfds_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tfds_pkg::ST_CLEAR;
      clr_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
      card_count_q <= tfds_pkg::COUNT_W'(1);
      for (int i = 0; i < tfds_pkg::ID_SLOTS; i++) begin
        card_id_q[i] <= tfds_pkg::CARD_ID_W'(i);
      end
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (tfds_pkg::reg_idx_e'(cfg_index_i))
          tfds_pkg::REG_CARD_COUNT: card_count_q <= cfg_data_i[tfds_pkg::COUNT_W-1:0];
          tfds_pkg::REG_CARD_ID_0:  card_id_q[0] <= cfg_data_i;
          tfds_pkg::REG_CARD_ID_1:  card_id_q[1] <= cfg_data_i;
          tfds_pkg::REG_CARD_ID_2:  card_id_q[2] <= cfg_data_i;
          tfds_pkg::REG_CARD_ID_3:  card_id_q[3] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload and working registers need no reset.
  always_ff @(posedge clk_i) begin
    slot_q      <= slot_d;
    byte_q      <= byte_d;
    board_q     <= board_d;
    sensor_q    <= sensor_d;
    upper_q     <= upper_d;
    rd_addr_q   <= rd_addr_d;
    rd_ok_q     <= rd_ok_d;
    out_value_q <= out_value_d;
    out_flag_q  <= out_flag_d;
    if (s_accept && s_axis_tuser_i == tfds_pkg::FUNC_FRAME) begin
      for (int k = 0; k < tfds_pkg::PAYLOAD_N; k++) begin
        pay_q[k] <= s_axis_tdata_i[19 + 8*k +: 8];
      end
    end
  end

  tfds_ram #(
    .WIDTH(8),
    .DEPTH(tfds_pkg::STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr_q),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_value_q;
  assign m_axis_tuser_o  = out_flag_q;

endmodule

// ===== src/tfds_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tfds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/tfds_checker.sv =====
// Port-level checks of the tactile frame demultiplexer and store, with their bind.
// Depends on tfds_pkg and the top level tactile_frame_demux_store.
module tfds_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid_i,
  input logic                                s_axis_tready_o,
  input logic [tfds_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  input logic                                s_axis_tuser_i,
  input logic                                m_axis_tvalid_o,
  input logic                                m_axis_tready_i,
  input logic [7:0]                          m_axis_tdata_o,
  input logic                                m_axis_tuser_o,
  input logic                                cfg_valid_i,
  input logic                                cfg_ready_o,
  input logic [tfds_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input logic [tfds_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  // A stalled result keeps its valid and its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // A position outside the slots in use reads as zero.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == 8'd0)
    else $error("invalid read returned nonzero value");

  // Every request keeps the block busy for at least the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("ready right after a request");

  // A frame request never produces a result.
  a_frame_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == tfds_pkg::FUNC_FRAME &&
      !m_axis_tvalid_o |=> !m_axis_tvalid_o)
    else $error("result after a frame request");

endmodule

bind tactile_frame_demux_store tfds_checker u_tfds_checker (.*);
